[design/fpp_pkg.sv]
// Shared types and constants for the FEN position parser.
`timescale 1ns / 1ps
`default_nettype none

package fpp_pkg;

    localparam logic [1:0] EV_CLEAR   = 2'd0;
    localparam logic [1:0] EV_PLACE   = 2'd1;
    localparam logic [1:0] EV_SUMMARY = 2'd2;

    localparam logic [2:0] PK_PAWN    = 3'd0;
    localparam logic [2:0] PK_KNIGHT  = 3'd1;
    localparam logic [2:0] PK_BISHOP  = 3'd2;
    localparam logic [2:0] PK_ROOK    = 3'd3;
    localparam logic [2:0] PK_QUEEN   = 3'd4;
    localparam logic [2:0] PK_KING    = 3'd5;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [5:0]  square;
        logic        piece_side;
        logic [2:0]  piece_kind;
        logic        side_to_move;
        logic [3:0]  castle_rights;
        logic        passant_valid;
        logic [5:0]  passant_square;
        logic [15:0] halfmove_count;
        logic [15:0] fullmove_count;
        logic        run_last;
    } t_result;

    // results produced by one step, in delivery order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

[design/fpp_step.sv]
// Per-byte FEN parse step: field state registers and result generation.
`timescale 1ns / 1ps
`default_nettype none

module fpp_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    output fpp_pkg::t_push     o_push
);
    import fpp_pkg::*;

    localparam logic [3:0] ST_WAIT       = 4'd0;
    localparam logic [3:0] ST_PLACE      = 4'd1;
    localparam logic [3:0] ST_SIDE_FIRST = 4'd2;
    localparam logic [3:0] ST_SIDE_SKIP  = 4'd3;
    localparam logic [3:0] ST_CASTLE     = 4'd4;
    localparam logic [3:0] ST_EP_FIRST   = 4'd5;
    localparam logic [3:0] ST_EP_RANK    = 4'd6;
    localparam logic [3:0] ST_AFTER_EP   = 4'd7;
    localparam logic [3:0] ST_HALF       = 4'd8;
    localparam logic [3:0] ST_FULL       = 4'd9;
    localparam logic [3:0] ST_DONE       = 4'd10;

    localparam logic [3:0] RANK_TOP  = 4'd7;
    localparam logic [3:0] RANK_OFF  = 4'd15;
    localparam logic [3:0] FILE_OFF  = 4'd8;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_K   = 8'h4B;
    localparam logic [7:0] CH_UP_Q   = 8'h51;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_H   = 8'h68;
    localparam logic [7:0] CH_LO_K   = 8'h6B;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_P   = 8'h70;
    localparam logic [7:0] CH_LO_Q   = 8'h71;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    logic [3:0]  r_stage, n_stage;
    logic [3:0]  r_rank, n_rank;
    logic [3:0]  r_file, n_file;
    logic        r_black, n_black;
    logic [3:0]  r_rights, n_rights;
    logic        r_ep_present, n_ep_present;
    logic [2:0]  r_ep_file, n_ep_file;
    logic [5:0]  r_ep_pos, n_ep_pos;
    logic [15:0] r_half, n_half;
    logic [15:0] r_full, n_full;

    logic        is_wait;
    logic [3:0]  e_stage;
    logic [3:0]  e_rank, e_file;
    logic        e_black, e_ep_present;
    logic [3:0]  e_rights;
    logic [2:0]  e_ep_file;
    logic [5:0]  e_ep_pos;
    logic [15:0] e_half, e_full;
    logic [19:0] half_sum;
    logic [15:0] half_next;
    logic [19:0] full_sum;
    logic [15:0] full_next;
    logic [4:0]  file_sum;
    logic [7:0]  lower;
    logic        piece_ok;
    logic [2:0]  piece_code;
    logic        has_second;
    t_result     second;
    t_result     clear_ev;

    // halfmove: acc*10 + (c - '0'), clamped to 0..65535
    assign half_sum  = {1'b0, e_half, 3'b000} + {3'b000, e_half, 1'b0} + {12'd0, i_byte};
    always_comb begin
        if (half_sum < {12'd0, CH_ZERO}) begin
            half_next = '0;
        end else if ((half_sum - {12'd0, CH_ZERO}) > {4'd0, CNT_MAX}) begin
            half_next = CNT_MAX;
        end else begin
            half_next = half_sum[15:0] - {8'd0, CH_ZERO};
        end
    end

    // fullmove: only called for decimal digits, low nibble is the digit
    assign full_sum  = {1'b0, e_full, 3'b000} + {3'b000, e_full, 1'b0} + {16'd0, i_byte[3:0]};
    assign full_next = (full_sum > {4'd0, CNT_MAX}) ? CNT_MAX : full_sum[15:0];

    assign file_sum = {1'b0, e_file} + {1'b0, i_byte[3:0]};
    assign lower    = (i_byte >= CH_UP_A && i_byte <= CH_UP_Z) ? (i_byte | 8'h20) : i_byte;

    always_comb begin
        piece_ok   = 1'b1;
        piece_code = PK_PAWN;
        case (lower)
            CH_LO_P: piece_code = PK_PAWN;
            CH_LO_N: piece_code = PK_KNIGHT;
            CH_LO_B: piece_code = PK_BISHOP;
            CH_LO_R: piece_code = PK_ROOK;
            CH_LO_Q: piece_code = PK_QUEEN;
            CH_LO_K: piece_code = PK_KING;
            default: piece_ok   = 1'b0;
        endcase
    end

    always_comb begin
        // the first byte of a record sees freshly started fields
        is_wait      = (r_stage == ST_WAIT);
        e_stage      = is_wait ? ST_PLACE : r_stage;
        e_rank       = is_wait ? RANK_TOP : r_rank;
        e_file       = is_wait ? 4'd0 : r_file;
        e_black      = is_wait ? 1'b0 : r_black;
        e_rights     = is_wait ? 4'd0 : r_rights;
        e_ep_present = is_wait ? 1'b0 : r_ep_present;
        e_ep_file    = is_wait ? 3'd0 : r_ep_file;
        e_ep_pos     = is_wait ? 6'd0 : r_ep_pos;
        e_half       = is_wait ? 16'd0 : r_half;
        e_full       = is_wait ? 16'd0 : r_full;

        n_stage      = e_stage;
        n_rank       = e_rank;
        n_file       = e_file;
        n_black      = e_black;
        n_rights     = e_rights;
        n_ep_present = e_ep_present;
        n_ep_file    = e_ep_file;
        n_ep_pos     = e_ep_pos;
        n_half       = e_half;
        n_full       = e_full;

        has_second = 1'b0;
        second     = '0;

        if (i_byte == 8'd0) begin
            has_second            = 1'b1;
            second.event_kind     = EV_SUMMARY;
            second.side_to_move   = e_black;
            second.castle_rights  = e_rights;
            second.passant_valid  = e_ep_present;
            second.passant_square = e_ep_present ? e_ep_pos : 6'd0;
            second.halfmove_count = e_half;
            second.fullmove_count = (e_full == 16'd0) ? 16'd1 : e_full;
            n_stage               = ST_WAIT;
        end else begin
            case (e_stage)
                ST_PLACE: begin
                    if (i_byte == CH_SPACE) begin
                        n_stage = ST_SIDE_FIRST;
                    end else if (i_byte == CH_SLASH) begin
                        n_rank = (e_rank == 4'd0 || e_rank == RANK_OFF) ? RANK_OFF
                                                                        : e_rank - 4'd1;
                        n_file = 4'd0;
                    end else if (i_byte >= CH_ONE && i_byte <= CH_EIGHT) begin
                        n_file = (file_sum > {1'b0, FILE_OFF}) ? FILE_OFF : file_sum[3:0];
                    end else begin
                        if (piece_ok && e_rank != RANK_OFF && e_file < FILE_OFF) begin
                            has_second         = 1'b1;
                            second.event_kind  = EV_PLACE;
                            second.square      = {e_rank[2:0], e_file[2:0]};
                            second.piece_side  = !(i_byte >= CH_UP_A && i_byte <= CH_UP_Z);
                            second.piece_kind  = piece_code;
                        end
                        if (e_file < FILE_OFF) begin
                            n_file = e_file + 4'd1;
                        end
                    end
                end
                ST_SIDE_FIRST: begin
                    n_black = (i_byte == CH_LO_B);
                    n_stage = (i_byte == CH_SPACE) ? ST_CASTLE : ST_SIDE_SKIP;
                end
                ST_SIDE_SKIP: begin
                    if (i_byte == CH_SPACE) begin
                        n_stage = ST_CASTLE;
                    end
                end
                ST_CASTLE: begin
                    if (i_byte == CH_SPACE) begin
                        n_stage = ST_EP_FIRST;
                    end else if (i_byte == CH_UP_K) begin
                        n_rights = e_rights | 4'b0001;
                    end else if (i_byte == CH_UP_Q) begin
                        n_rights = e_rights | 4'b0010;
                    end else if (i_byte == CH_LO_K) begin
                        n_rights = e_rights | 4'b0100;
                    end else if (i_byte == CH_LO_Q) begin
                        n_rights = e_rights | 4'b1000;
                    end
                end
                ST_EP_FIRST: begin
                    if (i_byte == CH_DASH) begin
                        n_ep_present = 1'b0;
                        n_stage      = ST_AFTER_EP;
                    end else if (i_byte >= CH_LO_A && i_byte <= CH_LO_H) begin
                        n_ep_file = i_byte[2:0] - CH_LO_A[2:0];
                        n_stage   = ST_EP_RANK;
                    end else if (i_byte == CH_SPACE) begin
                        n_stage = ST_HALF;
                    end else begin
                        n_half  = half_next;
                        n_stage = ST_HALF;
                    end
                end
                ST_EP_RANK: begin
                    if (i_byte >= CH_ONE && i_byte <= CH_EIGHT) begin
                        n_ep_present = 1'b1;
                        n_ep_pos     = {i_byte[2:0] - CH_ONE[2:0], e_ep_file};
                    end
                    n_stage = ST_AFTER_EP;
                end
                ST_AFTER_EP: begin
                    if (i_byte != CH_SPACE) begin
                        n_half = half_next;
                    end
                    n_stage = ST_HALF;
                end
                ST_HALF: begin
                    if (i_byte == CH_SPACE) begin
                        n_stage = ST_FULL;
                    end else begin
                        n_half = half_next;
                    end
                end
                ST_FULL: begin
                    if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                        n_full = full_next;
                    end else begin
                        n_stage = ST_DONE;
                    end
                end
                default: begin
                    // trailing text after the fullmove field is ignored
                end
            endcase
        end
    end

    always_comb begin
        clear_ev            = '0;
        clear_ev.event_kind = EV_CLEAR;
        clear_ev.run_last   = !has_second;
        o_push              = '0;
        if (is_wait) begin
            o_push.count           = has_second ? 2'd2 : 2'd1;
            o_push.first           = clear_ev;
            o_push.second          = second;
            o_push.second.run_last = 1'b1;
        end else if (has_second) begin
            o_push.count          = 2'd1;
            o_push.first          = second;
            o_push.first.run_last = 1'b1;
        end
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ST_WAIT;
            r_rank       <= RANK_TOP;
            r_file       <= '0;
            r_black      <= 1'b0;
            r_rights     <= '0;
            r_ep_present <= 1'b0;
            r_ep_file    <= '0;
            r_ep_pos     <= '0;
            r_half       <= '0;
            r_full       <= '0;
        end else if (i_fire) begin
            r_stage      <= n_stage;
            r_rank       <= n_rank;
            r_file       <= n_file;
            r_black      <= n_black;
            r_rights     <= n_rights;
            r_ep_present <= n_ep_present;
            r_ep_file    <= n_ep_file;
            r_ep_pos     <= n_ep_pos;
            r_half       <= n_half;
            r_full       <= n_full;
        end
    end

endmodule

`default_nettype wire

[design/fpp_out_fifo.sv]
// Result queue: takes up to two results a cycle, delivers one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module fpp_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fpp_pkg::t_push i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_stall,
    output fpp_pkg::t_result   o_result
);
    import fpp_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]     r_count, n_count;
    logic              pop;
    logic [Q_AW-1:0]   wr_ptr_next;

    assign o_valid     = (r_count != '0);
    assign o_room      = (r_count <= (Q_AW + 1)'(Q_DEPTH - 2));
    assign o_result    = r_mem[r_rd_ptr];
    assign pop         = o_valid && !i_stall;
    assign wr_ptr_next = r_wr_ptr + Q_AW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + Q_AW'(pop);
        n_count  = r_count + (Q_AW + 1)'(i_push.count) - (Q_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[design/fen_position_parser_unit.sv]
// FEN position parser top level: input register, parse step and result queue.
// A transferred byte is held in the input register, then parsed into the result
// queue, whose head drives o_valid and the result outputs.
// Throughput: one byte per cycle while the result queue has room for two results;
// a record's first byte that also places a piece or ends the record gives two results.
// Reset (synchronous, active low) empties the queue and rearms for a new record.
`timescale 1ns / 1ps
`default_nettype none

module fen_position_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_kind,
    output logic [5:0]       o_square,
    output logic             o_piece_side,
    output logic [2:0]       o_piece_kind,
    output logic             o_side_to_move,
    output logic [3:0]       o_castle_rights,
    output logic             o_passant_valid,
    output logic [5:0]       o_passant_square,
    output logic [15:0]      o_halfmove_count,
    output logic [15:0]      o_fullmove_count,
    output logic             o_run_last
);
    import fpp_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        in_xfer;
    logic        fire;
    logic        room;
    t_push       push;
    t_result     head;

    // the step needs space for two results before it consumes a byte
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign in_xfer = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_text_byte;
        end
    end

    fpp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    fpp_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head)
    );

    assign o_event_kind     = head.event_kind;
    assign o_square         = head.square;
    assign o_piece_side     = head.piece_side;
    assign o_piece_kind     = head.piece_kind;
    assign o_side_to_move   = head.side_to_move;
    assign o_castle_rights  = head.castle_rights;
    assign o_passant_valid  = head.passant_valid;
    assign o_passant_square = head.passant_square;
    assign o_halfmove_count = head.halfmove_count;
    assign o_fullmove_count = head.fullmove_count;
    assign o_run_last       = head.run_last;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the FEN position parser: byte streams in, board events checked.
`timescale 1ns / 1ps

module testbench;
    import fpp_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [3:0] OFF_BOARD_RANK = 4'd15;
    localparam logic [3:0] FILE_LIMIT     = 4'd8;

    localparam int RESET_CYCLES  = 8;
    localparam int STREAM_ITEMS  = 1900;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef enum logic [3:0] {
        PS_WAIT, PS_PLACE, PS_SIDE_FIRST, PS_SIDE_SKIP, PS_CASTLE, PS_EP_FIRST,
        PS_EP_RANK, PS_AFTER_EP, PS_HALF, PS_FULL, PS_DONE
    } t_parse_stage;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    class fen_scoreboard;
        t_parse_stage stage;
        logic [3:0]   rank_no;
        logic [3:0]   file_no;
        logic         black;
        logic [3:0]   rights;
        logic         ep_present;
        logic [2:0]   ep_file;
        logic [5:0]   ep_pos;
        logic [15:0]  half_acc;
        int unsigned  full_acc;
        t_result      event_q[$];
        int           fail_count;

        function new();
            clear_position();
            stage = PS_WAIT;
            fail_count = 0;
        endfunction

        function void clear_position();
            rank_no = 4'd7;
            file_no = 4'd0;
            black = 1'b0;
            rights = 4'd0;
            ep_present = 1'b0;
            ep_file = 3'd0;
            ep_pos = 6'd0;
            half_acc = 16'd0;
            full_acc = 0;
        endfunction

        function int piece_code(logic [7:0] c);
            logic [7:0] lc;
            lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
            case (lc)
                "p": return int'(PK_PAWN);
                "n": return int'(PK_KNIGHT);
                "b": return int'(PK_BISHOP);
                "r": return int'(PK_ROOK);
                "q": return int'(PK_QUEEN);
                "k": return int'(PK_KING);
                default: return -1;
            endcase
        endfunction

        // signed accumulate, clamped to the 16-bit range after every byte
        function void add_half_digit(logic [7:0] c);
            int v;
            v = int'(half_acc) * 10 + int'(c) - 48;
            if (v < 0) v = 0;
            else if (v > 65535) v = 65535;
            half_acc = v[15:0];
        endfunction

        function void note_byte(logic [7:0] c);
            t_result res[$];
            t_result ev;
            int kind;
            if (stage == PS_WAIT) begin
                clear_position();
                ev = '0;
                ev.event_kind = EV_CLEAR;
                res.push_back(ev);
                stage = PS_PLACE;
            end
            if (c == CH_NUL) begin
                ev = '0;
                ev.event_kind = EV_SUMMARY;
                ev.side_to_move = black;
                ev.castle_rights = rights;
                ev.passant_valid = ep_present;
                ev.passant_square = ep_present ? ep_pos : 6'd0;
                ev.halfmove_count = half_acc;
                ev.fullmove_count = (full_acc == 0) ? 16'd1 : full_acc[15:0];
                res.push_back(ev);
                stage = PS_WAIT;
            end else begin
                case (stage)
                    PS_PLACE: begin
                        if (c == CH_SPACE) begin
                            stage = PS_SIDE_FIRST;
                        end else if (c == CH_SLASH) begin
                            rank_no = (rank_no == 4'd0 || rank_no == OFF_BOARD_RANK) ?
                                      OFF_BOARD_RANK : rank_no - 4'd1;
                            file_no = 4'd0;
                        end else if (c >= "1" && c <= "8") begin
                            if (int'(file_no) + int'(c[3:0]) > 8) file_no = FILE_LIMIT;
                            else file_no = file_no + c[3:0];
                        end else begin
                            kind = piece_code(c);
                            if (kind >= 0 && rank_no != OFF_BOARD_RANK && file_no < FILE_LIMIT) begin
                                ev = '0;
                                ev.event_kind = EV_PLACE;
                                ev.square = {rank_no[2:0], file_no[2:0]};
                                ev.piece_side = !(c >= "A" && c <= "Z");
                                ev.piece_kind = kind[2:0];
                                res.push_back(ev);
                            end
                            if (file_no < FILE_LIMIT) file_no = file_no + 4'd1;
                        end
                    end
                    PS_SIDE_FIRST: begin
                        black = (c == "b");
                        stage = (c == CH_SPACE) ? PS_CASTLE : PS_SIDE_SKIP;
                    end
                    PS_SIDE_SKIP: if (c == CH_SPACE) stage = PS_CASTLE;
                    PS_CASTLE: begin
                        if (c == CH_SPACE) stage = PS_EP_FIRST;
                        else if (c == "K") rights[0] = 1'b1;
                        else if (c == "Q") rights[1] = 1'b1;
                        else if (c == "k") rights[2] = 1'b1;
                        else if (c == "q") rights[3] = 1'b1;
                    end
                    PS_EP_FIRST: begin
                        if (c == CH_DASH) begin
                            ep_present = 1'b0;
                            stage = PS_AFTER_EP;
                        end else if (c >= "a" && c <= "h") begin
                            ep_file = c[2:0] - 3'd1;
                            stage = PS_EP_RANK;
                        end else if (c == CH_SPACE) begin
                            stage = PS_HALF;
                        end else begin
                            add_half_digit(c);
                            stage = PS_HALF;
                        end
                    end
                    PS_EP_RANK: begin
                        if (c >= "1" && c <= "8") begin
                            ep_present = 1'b1;
                            ep_pos = {c[2:0] - 3'd1, ep_file};
                        end
                        stage = PS_AFTER_EP;
                    end
                    PS_AFTER_EP: begin
                        if (c != CH_SPACE) add_half_digit(c);
                        stage = PS_HALF;
                    end
                    PS_HALF: begin
                        if (c == CH_SPACE) stage = PS_FULL;
                        else add_half_digit(c);
                    end
                    PS_FULL: begin
                        if (c >= "0" && c <= "9") begin
                            full_acc = full_acc * 10 + c[3:0];
                            if (full_acc > 65535) full_acc = 65535;
                        end else begin
                            stage = PS_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
            foreach (res[i]) event_q.push_back(res[i]);
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (event_q.size() == 0) begin
                $error("event_kind: expected none pending, got %0d", got.event_kind);
                fail_count++;
                return;
            end
            want = event_q.pop_front();
            check_field("event_kind", want.event_kind, got.event_kind);
            check_field("square", want.square, got.square);
            check_field("piece_side", want.piece_side, got.piece_side);
            check_field("piece_kind", want.piece_kind, got.piece_kind);
            check_field("side_to_move", want.side_to_move, got.side_to_move);
            check_field("castle_rights", want.castle_rights, got.castle_rights);
            check_field("passant_valid", want.passant_valid, got.passant_valid);
            check_field("passant_square", want.passant_square, got.passant_square);
            check_field("halfmove_count", want.halfmove_count, got.halfmove_count);
            check_field("fullmove_count", want.fullmove_count, got.fullmove_count);
            check_field("run_last", want.run_last, got.run_last);
        endfunction

        function int pending_count();
            return event_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [5:0]  o_square;
    logic        o_piece_side;
    logic [2:0]  o_piece_kind;
    logic        o_side_to_move;
    logic [3:0]  o_castle_rights;
    logic        o_passant_valid;
    logic [5:0]  o_passant_square;
    logic [15:0] o_halfmove_count;
    logic [15:0] o_fullmove_count;
    logic        o_run_last;

    fen_scoreboard sb = new();
    logic [7:0]    text_q[$];
    int            accepted_bytes = 0;
    t_result       seen_event;

    fen_position_parser_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_text_byte      (i_text_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_square         (o_square),
        .o_piece_side     (o_piece_side),
        .o_piece_kind     (o_piece_kind),
        .o_side_to_move   (o_side_to_move),
        .o_castle_rights  (o_castle_rights),
        .o_passant_valid  (o_passant_valid),
        .o_passant_square (o_passant_square),
        .o_halfmove_count (o_halfmove_count),
        .o_fullmove_count (o_fullmove_count),
        .o_run_last       (o_run_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] noise_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void add_digits();
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
        repeat (n) text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
    endfunction

    // mostly well-formed records with random content; some noise and truncation
    function automatic void add_record();
        int    start, ranks, f, d, sel, keep;
        string pieces;
        pieces = "pnbrqkPNBRQK";
        start = text_q.size();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 12)) text_q.push_back(noise_byte());
            text_q.push_back(CH_NUL);
            return;
        end
        ranks = ($urandom_range(0, 1) == 0) ? 8 : $urandom_range(0, 10);
        for (int r = 0; r < ranks; r++) begin
            f = 0;
            if (r > 0) text_q.push_back(CH_SLASH);
            while (f < 8) begin
                if ($urandom_range(0, 1) == 0) begin
                    d = $urandom_range(1, 8 - f);
                    text_q.push_back(8'(8'h30 + d));
                    f += d;
                end else begin
                    text_q.push_back(pieces[$urandom_range(0, 11)]);
                    f++;
                end
                if ($urandom_range(0, 24) == 0) text_q.push_back(noise_byte());
            end
        end
        text_q.push_back(CH_SPACE);
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            text_q.push_back("w");
        end else if (sel < 8) begin
            text_q.push_back("b");
        end else if (sel == 8) begin
            text_q.push_back("b");
            text_q.push_back(noise_byte());
        end
        text_q.push_back(CH_SPACE);
        if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CH_DASH);
        end else begin
            if ($urandom_range(0, 1) == 0) text_q.push_back("K");
            if ($urandom_range(0, 1) == 0) text_q.push_back("Q");
            if ($urandom_range(0, 1) == 0) text_q.push_back("k");
            if ($urandom_range(0, 1) == 0) text_q.push_back("q");
            if ($urandom_range(0, 5) == 0) text_q.push_back(noise_byte());
        end
        text_q.push_back(CH_SPACE);
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
            text_q.push_back(CH_DASH);
        end else if (sel < 17) begin
            text_q.push_back(8'($urandom_range(8'h61, 8'h68)));
            text_q.push_back((sel == 16) ? noise_byte() : 8'($urandom_range(8'h31, 8'h38)));
        end else if (sel < 19) begin
            text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        text_q.push_back(CH_SPACE);
        add_digits();
        if ($urandom_range(0, 9) == 0) text_q.push_back(noise_byte());
        text_q.push_back(CH_SPACE);
        add_digits();
        if ($urandom_range(0, 4) == 0) begin
            text_q.push_back(noise_byte());
            add_digits();
        end
        if ($urandom_range(0, 7) == 0) begin
            keep = $urandom_range(start, text_q.size());
            while (text_q.size() > keep) void'(text_q.pop_back());
        end
        text_q.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        i_valid <= 1'b1;
        i_text_byte <= value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            sb.note_byte(i_text_byte);
            accepted_bytes++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            seen_event.event_kind = o_event_kind;
            seen_event.square = o_square;
            seen_event.piece_side = o_piece_side;
            seen_event.piece_kind = o_piece_kind;
            seen_event.side_to_move = o_side_to_move;
            seen_event.castle_rights = o_castle_rights;
            seen_event.passant_valid = o_passant_valid;
            seen_event.passant_square = o_passant_square;
            seen_event.halfmove_count = o_halfmove_count;
            seen_event.fullmove_count = o_fullmove_count;
            seen_event.run_last = o_run_last;
            sb.check_result(seen_event);
        end
    end

    // receiver: stall pattern in stretches, plus one long hold-off to back the block up
    initial begin
        t_rx_mode mode;
        int       stretch;
        bit       held;
        held = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 2));
            stretch = $urandom_range(8, 80);
            repeat (stretch) begin
                @(posedge i_clk);
                if (!held && accepted_bytes >= HOLD_AFTER) begin
                    held = 1'b1;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        RX_FREE:  i_stall <= 1'b0;
                        RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                        default:  i_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        int burst, gap;
        // empty record
        text_q.push_back(CH_NUL);
        // off-board ranks, unknown bytes, side skip, junk castle letter,
        // en passant with a bad rank, odd halfmove byte, fullmove of zero
        add_text("pK9");
        text_q.push_back(8'hFF);
        add_text("////////Q bx Kkz a9 ");
        text_q.push_back(8'hFF);
        add_text("7 0");
        text_q.push_back(CH_NUL);
        // record ends where the en passant rank should be
        add_text("N w - e");
        text_q.push_back(CH_NUL);
        // bare side field, valid en passant, both counters saturating, trailing junk
        add_text("  - c6 999999 99999x1");
        text_q.push_back(CH_NUL);
        while (text_q.size() < STREAM_ITEMS) add_record();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (text_q.size() > 0) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
            while (burst > 0 && text_q.size() > 0) begin
                send_byte(text_q.pop_front());
                burst--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_text_byte <= 8'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
design/fpp_pkg.sv
design/fpp_step.sv
design/fpp_out_fifo.sv
design/fen_position_parser_unit.sv
verif/testbench.sv
